FILE: rtl/buddy_page_allocator_top_macros.svh
// ----------------------------------------------------------------------------
// Buddy page allocator: assertion macros
// Immediate-consequence and next-cycle checks, clocked on clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_TOP_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define BPA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("buddy allocator check failed");

`define BPA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("buddy allocator check failed");

`else

`define BPA_ASSERT_IMP(lbl, ante, cons)

`define BPA_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Sizes, codes and storage word layouts shared by the allocator files.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int NPAGES     = 1024;
  localparam int TOP_ORD    = 10;
  localparam int PW         = $clog2(NPAGES);       // page index width
  localparam int LW         = PW + 1;               // link width, holds the empty mark
  localparam int OW         = $clog2(TOP_ORD + 1);  // order width
  localparam int SOW        = OW + 1;               // stored order, signed
  localparam int CW         = 11;                   // page count / register width
  localparam int NL         = TOP_ORD + 1;          // number of free lists

  typedef logic [PW-1:0] page_t;
  typedef logic [LW-1:0] link_t;
  typedef logic [OW-1:0] ord_t;

  localparam link_t NIL = link_t'(NPAGES);
  localparam logic [SOW-1:0] ORD_RSV = '1;          // reserved page marker

  typedef struct packed {
    logic            used;
    page_t           start;
    logic [SOW-1:0]  ord;
  } meta_t;

  typedef struct packed {
    link_t nxt;
    link_t prv;
  } lnk_t;

  localparam logic [1:0] K_ALLOC = 2'd0;
  localparam logic [1:0] K_FREE  = 2'd1;
  localparam logic [1:0] K_INIT  = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_NOBLK = 2'd1;
  localparam logic [1:0] ST_INVAL = 2'd2;
  localparam logic [1:0] ST_DUP   = 2'd3;

  localparam logic CFG_TOTAL = 1'b0;
  localparam logic CFG_RSV   = 1'b1;

  // smallest order whose block holds cnt pages, TOP_ORD if none below it
  function automatic ord_t round_order(input logic [CW-1:0] cnt);
    ord_t          r;
    logic [CW:0]   sz;
    r = ord_t'(TOP_ORD);
    for (int o = TOP_ORD; o >= 0; o--) begin
      sz = (CW+1)'(1) << o;
      if (sz >= {1'b0, cnt}) r = ord_t'(o);
    end
    return r;
  endfunction

  // offset of the last page in a block of the given order
  function automatic page_t blk_last(input ord_t o);
    logic [LW-1:0] sz;
    sz = LW'(1) << o;
    return page_t'(sz - LW'(1));
  endfunction

endpackage

FILE: rtl/bpa_ram.sv
// ----------------------------------------------------------------------------
// Buddy page allocator: storage array
// One write port with a bit mask, one read port with registered data.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int AW = 10,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [DW-1:0] wmask,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      for (int b = 0; b < DW; b++) begin
        if (wmask[b]) mem[waddr][b] <= wdata[b];
      end
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/buddy_page_allocator_top.sv
// ----------------------------------------------------------------------------
// Buddy page allocator, top level
// Page metadata and list links live in two synchronous arrays; a sequencer
// reads, modifies and writes them back one access per cycle.
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------
//  in       | in_valid / in_stall | in_kind, in_pg_cnt, in_page_index
//  out      | out_valid/out_stall | out_status, out_block_page, out_block_order
//  cfg      | cfg_we              | cfg_index, cfg_wdata
//
//  One item at a time. Alloc splits a list block of order k down to the order o
//  granted; free checks the block and merges it upwards with free buddies; init
//  rewrites every page. The metadata write port writes one page per cycle.
//  After reset a clearing pass over every page runs before the first item.
//  A result waits in the output register while out_stall is high.
// ----------------------------------------------------------------------------
`include "buddy_page_allocator_top_macros.svh"

module buddy_page_allocator_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_kind,
  input  logic [10:0]          in_pg_cnt,
  input  logic [9:0]           in_page_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_status,
  output bpa_pkg::page_t       out_block_page,
  output bpa_pkg::ord_t        out_block_order,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [bpa_pkg::CW-1:0] cfg_wdata
);

  import bpa_pkg::*;

  typedef enum logic [4:0] {
    S_ISWP, S_IDLE, S_DEC, S_ISRCH, S_APOP, S_ASPLIT, S_PUSH2, S_SWP,
    S_FMETA, S_FCHK, S_FCHK2, S_FMERGE, S_FBUD, S_FUNL, S_FUNL2, S_FPUSH, S_OUT
  } state_t;

  state_t state_r, state_nxt, ret_r, ret_nxt;

  // request and configuration
  logic [1:0]    kind_r, kind_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  page_t         idx_r, idx_nxt;
  logic [CW-1:0] total_r, total_nxt, rsv_r, rsv_nxt;
  link_t         region_r, region_nxt;
  link_t         head_r [NL];
  link_t         head_nxt [NL];

  // block walk
  ord_t          ord_r, ord_nxt, cur_r, cur_nxt;
  page_t         base_r, base_nxt, bud_r, bud_nxt, i_r, i_nxt;
  page_t         sw_base_r, sw_base_nxt;
  ord_t          sw_ord_r, sw_ord_nxt;
  logic          sw_uwe_r, sw_uwe_nxt, sw_mwe_r, sw_mwe_nxt, sw_uv_r, sw_uv_nxt;
  link_t         h_r, h_nxt, nx_r, nx_nxt, pv_r, pv_nxt;
  logic          busy_r, busy_nxt, chkv_r, chkv_nxt;

  // initialise
  link_t         t_r, t_nxt, r_r, r_nxt, tf_r, tf_nxt, last_r, last_nxt;
  logic [LW:0]   a_r, a_nxt;
  ord_t          io_r, io_nxt;
  logic          found_r, found_nxt, emit_r, emit_nxt;

  // result
  logic [1:0]    st_r, st_nxt;
  page_t         pg_r, pg_nxt;
  ord_t          od_r, od_nxt;

  // storage ports
  logic  m_we, l_we;
  page_t m_waddr, m_raddr, l_waddr, l_raddr;
  meta_t m_wdata, m_wmask, m_rd;
  lnk_t  l_wdata, l_wmask, l_rd;

  bpa_ram #(.AW(PW), .DW($bits(meta_t))) u_meta (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata), .wmask(m_wmask),
    .raddr(m_raddr), .rdata(m_rd)
  );

  bpa_ram #(.AW(PW), .DW($bits(lnk_t))) u_link (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata), .wmask(l_wmask),
    .raddr(l_raddr), .rdata(l_rd)
  );

  // combinational helpers
  ord_t          ro;
  logic          has;
  ord_t          cf;
  logic [LW:0]   sz_x, a_x, tf_x;
  link_t         sz_w, pw;
  page_t         msk, p, bud;
  logic          in_blk;
  link_t         fsz;
  logic          bad;

  always_comb begin
    state_nxt = state_r;   ret_nxt = ret_r;
    kind_nxt = kind_r;     cnt_nxt = cnt_r;     idx_nxt = idx_r;
    total_nxt = total_r;   rsv_nxt = rsv_r;     region_nxt = region_r;
    for (int k = 0; k < NL; k++) head_nxt[k] = head_r[k];
    ord_nxt = ord_r;       cur_nxt = cur_r;     base_nxt = base_r;
    bud_nxt = bud_r;       i_nxt = i_r;
    sw_base_nxt = sw_base_r; sw_ord_nxt = sw_ord_r;
    sw_uwe_nxt = sw_uwe_r; sw_mwe_nxt = sw_mwe_r; sw_uv_nxt = sw_uv_r;
    h_nxt = h_r;           nx_nxt = nx_r;       pv_nxt = pv_r;
    busy_nxt = busy_r;     chkv_nxt = chkv_r;
    t_nxt = t_r;           r_nxt = r_r;         tf_nxt = tf_r;
    last_nxt = last_r;     a_nxt = a_r;         io_nxt = io_r;
    found_nxt = found_r;   emit_nxt = emit_r;
    st_nxt = st_r;         pg_nxt = pg_r;       od_nxt = od_r;

    m_we = 1'b0; m_waddr = '0; m_wdata = '0; m_wmask = '0; m_raddr = '0;
    l_we = 1'b0; l_waddr = '0; l_wdata = '0; l_wmask = '0; l_raddr = '0;

    // configuration writes must arrive only while idle; the block does not enforce this
    if (cfg_we) begin
      if (cfg_index == CFG_TOTAL) total_nxt = cfg_wdata;
      else                        rsv_nxt   = cfg_wdata;
    end

    ro  = round_order(cnt_r);
    has = 1'b0;
    cf  = '0;
    for (int k = TOP_ORD; k >= 0; k--) begin
      if (ord_t'(k) >= ro && head_r[k] != NIL) begin
        has = 1'b1;
        cf  = ord_t'(k);
      end
    end

    sz_x = (LW+1)'(1) << io_r;
    a_x  = ({1'b0, r_r} + sz_x - (LW+1)'(1)) & ~(sz_x - (LW+1)'(1));
    tf_x = {1'b0, t_r} & ~(sz_x - (LW+1)'(1));
    sz_w = LW'(1) << io_r;
    msk  = page_t'(sz_w - LW'(1));
    pw   = {1'b0, i_r};
    in_blk = found_r && ({1'b0, pw} >= a_r) && (pw < tf_r);
    p    = sw_base_r + i_r;
    bud  = base_r ^ page_t'(LW'(1) << ord_r);
    fsz  = LW'(1) << m_rd.ord[OW-1:0];
    bad  = 1'b0;

    case (state_r)
      // clearing pass after reset, and the init rewrite of every page
      S_ISWP: begin
        m_we = 1'b1; m_waddr = i_r; m_wmask = '1;
        if (pw < r_r) begin
          m_wdata.used = 1'b1; m_wdata.start = i_r; m_wdata.ord = ORD_RSV;
        end else if (in_blk) begin
          m_wdata.start = i_r & ~msk; m_wdata.ord = SOW'(io_r);
        end
        if (in_blk && (i_r & msk) == '0) begin
          l_we = 1'b1; l_waddr = i_r; l_wmask = '1;
          l_wdata.nxt = ({1'b0, pw} == a_r) ? NIL : pw - sz_w;
          l_wdata.prv = (pw == last_r) ? NIL : pw + sz_w;
        end
        i_nxt = i_r + page_t'(1);
        if (i_r == page_t'(NPAGES - 1)) begin
          for (int k = 0; k < NL; k++) head_nxt[k] = NIL;
          if (found_r) head_nxt[io_r] = last_r;
          region_nxt = t_r;
          st_nxt = ST_DONE; pg_nxt = '0; od_nxt = '0;
          state_nxt = emit_r ? S_OUT : S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          kind_nxt = in_kind; cnt_nxt = in_pg_cnt; idx_nxt = in_page_index;
          state_nxt = S_DEC;
        end
      end

      S_DEC: begin
        st_nxt = ST_INVAL; pg_nxt = '0; od_nxt = '0;
        state_nxt = S_OUT;
        case (kind_r)
          K_ALLOC: begin
            if (cnt_r != '0 && ro < ord_t'(TOP_ORD)) begin
              if (!has) begin
                st_nxt = ST_NOBLK;
              end else begin
                l_raddr = head_r[cf][PW-1:0];
                base_nxt = head_r[cf][PW-1:0];
                cur_nxt = cf; ord_nxt = ro;
                state_nxt = S_APOP;
              end
            end
          end
          K_FREE: begin
            if (cnt_r != '0 && {1'b0, idx_r} < region_r) begin
              m_raddr = idx_r; busy_nxt = 1'b0;
              state_nxt = S_FMETA;
            end
          end
          K_INIT: begin
            t_nxt = (total_r < LW'(NPAGES)) ? LW'(total_r) : LW'(NPAGES);
            r_nxt = (LW'(rsv_r) < t_nxt) ? LW'(rsv_r) : t_nxt;
            io_nxt = ord_t'(TOP_ORD); emit_nxt = 1'b1;
            state_nxt = S_ISRCH;
          end
          default: ;
        endcase
      end

      // largest order with at least one whole block above the reserved pages
      S_ISRCH: begin
        if (a_x + sz_x <= {1'b0, t_r}) begin
          found_nxt = 1'b1; a_nxt = a_x; tf_nxt = LW'(tf_x);
          last_nxt = LW'(tf_x - sz_x); i_nxt = '0;
          state_nxt = S_ISWP;
        end else if (io_r == '0) begin
          found_nxt = 1'b0; i_nxt = '0;
          state_nxt = S_ISWP;
        end else begin
          io_nxt = io_r - ord_t'(1);
        end
      end

      S_APOP: begin
        head_nxt[cur_r] = l_rd.nxt;
        if (l_rd.nxt < NIL) begin
          l_we = 1'b1; l_waddr = l_rd.nxt[PW-1:0]; l_wdata.prv = NIL;
          l_wmask.prv = '1;
        end
        state_nxt = S_ASPLIT;
      end

      // split off the upper half and push it, or grant the block once at the requested order
      S_ASPLIT: begin
        if (cur_r > ord_r) begin
          cur_nxt = cur_r - ord_t'(1);
          bud_nxt = base_r + page_t'(LW'(1) << cur_nxt);
          l_we = 1'b1; l_waddr = bud_nxt; l_wmask = '1;
          l_wdata.nxt = head_r[cur_nxt]; l_wdata.prv = NIL;
          h_nxt = head_r[cur_nxt];
          head_nxt[cur_nxt] = {1'b0, bud_nxt};
          state_nxt = S_PUSH2;
        end else begin
          sw_base_nxt = base_r; sw_ord_nxt = ord_r;
          sw_uwe_nxt = 1'b1; sw_mwe_nxt = 1'b1; sw_uv_nxt = 1'b1;
          st_nxt = ST_DONE; pg_nxt = base_r; od_nxt = ord_r;
          i_nxt = '0; ret_nxt = S_OUT; state_nxt = S_SWP;
        end
      end

      S_PUSH2: begin
        if (h_r < NIL) begin
          l_we = 1'b1; l_waddr = h_r[PW-1:0]; l_wdata.prv = {1'b0, bud_r};
          l_wmask.prv = '1;
        end
        if (kind_r == K_ALLOC) begin
          sw_base_nxt = bud_r; sw_ord_nxt = cur_r;
          sw_uwe_nxt = 1'b1; sw_mwe_nxt = 1'b1; sw_uv_nxt = 1'b0;
          i_nxt = '0; ret_nxt = S_ASPLIT; state_nxt = S_SWP;
        end else begin
          st_nxt = ST_DONE; pg_nxt = bud_r; od_nxt = ord_r;
          state_nxt = S_OUT;
        end
      end

      // one page of a block per cycle
      S_SWP: begin
        m_we = 1'b1; m_waddr = p;
        m_wdata.used = sw_uv_r; m_wdata.start = sw_base_r; m_wdata.ord = SOW'(sw_ord_r);
        m_wmask.used = sw_uwe_r;
        if (sw_mwe_r && {1'b0, p} < region_r) begin
          m_wmask.start = '1; m_wmask.ord = '1;
        end
        i_nxt = i_r + page_t'(1);
        if (i_r == blk_last(sw_ord_r)) begin
          i_nxt = '0; state_nxt = ret_r;
        end
      end

      S_FMETA: begin
        bad = ({1'b0, m_rd.start} >= region_r) || m_rd.ord[SOW-1] ||
              (m_rd.ord > SOW'(TOP_ORD));
        if (!bad)
          bad = (cnt_r > CW'(fsz)) || ((m_rd.start & page_t'(fsz - LW'(1))) != '0);
        if (bad) begin
          st_nxt = ST_INVAL; pg_nxt = '0; od_nxt = '0;
          state_nxt = S_OUT;
        end else begin
          base_nxt = m_rd.start; ord_nxt = m_rd.ord[OW-1:0];
          i_nxt = '0; chkv_nxt = 1'b0;
          state_nxt = S_FCHK;
        end
      end

      // scan the block for any used page
      S_FCHK: begin
        m_raddr = base_r + i_r;
        chkv_nxt = 1'b1;
        if (chkv_r && m_rd.used) busy_nxt = 1'b1;
        i_nxt = i_r + page_t'(1);
        if (i_r == blk_last(ord_r)) begin
          i_nxt = '0; state_nxt = S_FCHK2;
        end
      end

      S_FCHK2: begin
        if (!(busy_r || m_rd.used)) begin
          st_nxt = ST_DUP; pg_nxt = base_r; od_nxt = ord_r;
          state_nxt = S_OUT;
        end else begin
          sw_base_nxt = base_r; sw_ord_nxt = ord_r;
          sw_uwe_nxt = 1'b1; sw_mwe_nxt = 1'b0; sw_uv_nxt = 1'b0;
          i_nxt = '0; ret_nxt = S_FMERGE; state_nxt = S_SWP;
        end
      end

      S_FMERGE: begin
        if (ord_r < ord_t'(TOP_ORD) && {1'b0, bud} < region_r) begin
          m_raddr = bud; bud_nxt = bud;
          state_nxt = S_FBUD;
        end else begin
          sw_base_nxt = base_r; sw_ord_nxt = ord_r;
          sw_uwe_nxt = 1'b0; sw_mwe_nxt = 1'b1; sw_uv_nxt = 1'b0;
          i_nxt = '0; ret_nxt = S_FPUSH; state_nxt = S_SWP;
        end
      end

      S_FBUD: begin
        if (m_rd.start == bud_r && m_rd.ord == SOW'(ord_r) && !m_rd.used) begin
          l_raddr = bud_r;
          state_nxt = S_FUNL;
        end else begin
          sw_base_nxt = base_r; sw_ord_nxt = ord_r;
          sw_uwe_nxt = 1'b0; sw_mwe_nxt = 1'b1; sw_uv_nxt = 1'b0;
          i_nxt = '0; ret_nxt = S_FPUSH; state_nxt = S_SWP;
        end
      end

      // unlink the buddy from its list
      S_FUNL: begin
        if (l_rd.prv < NIL) begin
          l_we = 1'b1; l_waddr = l_rd.prv[PW-1:0]; l_wdata.nxt = l_rd.nxt;
          l_wmask.nxt = '1;
        end else begin
          head_nxt[ord_r] = l_rd.nxt;
        end
        nx_nxt = l_rd.nxt; pv_nxt = l_rd.prv;
        state_nxt = S_FUNL2;
      end

      S_FUNL2: begin
        if (nx_r < NIL) begin
          l_we = 1'b1; l_waddr = nx_r[PW-1:0]; l_wdata.prv = pv_r;
          l_wmask.prv = '1;
        end
        if (bud_r < base_r) base_nxt = bud_r;
        ord_nxt = ord_r + ord_t'(1);
        state_nxt = S_FMERGE;
      end

      S_FPUSH: begin
        l_we = 1'b1; l_waddr = base_r; l_wmask = '1;
        l_wdata.nxt = head_r[ord_r]; l_wdata.prv = NIL;
        h_nxt = head_r[ord_r];
        head_nxt[ord_r] = {1'b0, base_r};
        bud_nxt = base_r;
        state_nxt = S_PUSH2;
      end

      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ISWP;   ret_r <= S_IDLE;
      total_r <= CW'(NPAGES); rsv_r <= '0;
      region_r <= '0;      i_r <= '0;
      t_r <= '0;           r_r <= '0;
      found_r <= 1'b0;     emit_r <= 1'b0;
      busy_r <= 1'b0;      chkv_r <= 1'b0;
      for (int k = 0; k < NL; k++) head_r[k] <= NIL;
    end else begin
      state_r <= state_nxt; ret_r <= ret_nxt;
      total_r <= total_nxt; rsv_r <= rsv_nxt;
      region_r <= region_nxt; i_r <= i_nxt;
      t_r <= t_nxt;         r_r <= r_nxt;
      found_r <= found_nxt; emit_r <= emit_nxt;
      busy_r <= busy_nxt;   chkv_r <= chkv_nxt;
      for (int k = 0; k < NL; k++) head_r[k] <= head_nxt[k];
    end
    kind_r <= kind_nxt;   cnt_r <= cnt_nxt;   idx_r <= idx_nxt;
    ord_r <= ord_nxt;     cur_r <= cur_nxt;   base_r <= base_nxt;
    bud_r <= bud_nxt;
    sw_base_r <= sw_base_nxt; sw_ord_r <= sw_ord_nxt;
    sw_uwe_r <= sw_uwe_nxt;   sw_mwe_r <= sw_mwe_nxt; sw_uv_r <= sw_uv_nxt;
    h_r <= h_nxt;         nx_r <= nx_nxt;     pv_r <= pv_nxt;
    tf_r <= tf_nxt;       last_r <= last_nxt; a_r <= a_nxt;  io_r <= io_nxt;
    st_r <= st_nxt;       pg_r <= pg_nxt;     od_r <= od_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = (state_r == S_OUT);
  assign out_status      = st_r;
  assign out_block_page  = pg_r;
  assign out_block_order = od_r;

  logic fail_out;
  assign fail_out = out_valid && (out_status == ST_NOBLK || out_status == ST_INVAL);

  `BPA_ASSERT_NXT(a_accept_busy, in_valid && !in_stall, in_stall)
  `BPA_ASSERT_IMP(a_out_holds_in, out_valid, in_stall)
  `BPA_ASSERT_IMP(a_fail_zero, fail_out, out_block_page == '0 && out_block_order == '0)
  `BPA_ASSERT_IMP(a_order_range, out_valid, out_block_order <= ord_t'(TOP_ORD))

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// Buddy page allocator testbench
// Drives alloc, free, init and invalid-kind requests through the valid/stall channels with
// random gaps and back-pressure, predicts every result with a behavioural
// model of the allocator kept in the bench, and checks each result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import bpa_pkg::*;

  localparam int WDOG_LIMIT = 40000;
  localparam int NIL_I      = NPAGES;

  typedef struct {
    logic [1:0] status;
    int         page;
    int         order;
  } alloc_rsp_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [1:0]    in_kind = K_ALLOC;
  logic [10:0]   in_pg_cnt = '0;
  logic [9:0]    in_page_index = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [1:0]    out_status;
  page_t         out_block_page;
  ord_t          out_block_order;
  logic          cfg_we = 1'b0;
  logic          cfg_index = CFG_TOTAL;
  logic [CW-1:0] cfg_wdata = '0;

  // Model state of the allocator
  int   m_total = 1024;
  int   m_rsv   = 0;
  int   m_region = 0;
  bit   m_used [NPAGES];
  int   m_start [NPAGES];
  int   m_order [NPAGES];
  int   m_next [NPAGES];
  int   m_prev [NPAGES];
  int   m_head [NL];

  alloc_rsp_t rsp_pending [$];
  int   live_page [$];
  int   live_order [$];

  int   mismatches = 0;
  int   idle_cycles = 0;
  bit   no_idle = 1'b0;
  bit   hold_off_req = 1'b0;

  buddy_page_allocator_top i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_kind, .in_pg_cnt, .in_page_index,
    .out_valid, .out_stall, .out_status, .out_block_page, .out_block_order,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Free list model
  // --------------------------------------------------------------------------
  function automatic void list_push(int o, int n);
    int h;
    h = m_head[o];
    m_next[n] = h;
    m_prev[n] = NIL_I;
    if (h < NPAGES) m_prev[h] = n;
    m_head[o] = n;
  endfunction

  function automatic int list_pop(int o);
    int n;
    int nx;
    n = m_head[o];
    nx = m_next[n];
    m_head[o] = nx;
    if (nx < NPAGES) m_prev[nx] = NIL_I;
    return n;
  endfunction

  function automatic void list_unlink(int o, int n);
    int p;
    int nx;
    p = m_prev[n];
    nx = m_next[n];
    if (p < NPAGES) m_next[p] = nx;
    else m_head[o] = nx;
    if (nx < NPAGES) m_prev[nx] = p;
  endfunction

  function automatic void tag_block(int s, int o);
    for (int i = 0; i < (1 << o); i++) begin
      if (s + i < m_region && s + i < NPAGES) begin
        m_start[s + i] = s;
        m_order[s + i] = o;
      end
    end
  endfunction

  function automatic void mark_block(int s, int o, bit v);
    for (int i = 0; i < (1 << o); i++)
      if (s + i < NPAGES) m_used[s + i] = v;
  endfunction

  function automatic bit block_is_free(int s, int o);
    for (int i = 0; i < (1 << o); i++)
      if (s + i < NPAGES && m_used[s + i]) return 1'b0;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Request models
  // --------------------------------------------------------------------------
  function automatic void seed_lists();
    int t;
    int r;
    int sz;
    int a;
    t = (m_total < NPAGES) ? m_total : NPAGES;
    r = (m_rsv < t) ? m_rsv : t;
    m_region = t;
    for (int i = 0; i < NPAGES; i++) begin
      m_used[i] = (i < r);
      m_start[i] = (i < r) ? i : 0;
      m_order[i] = (i < r) ? -1 : 0;
    end
    for (int o = 0; o < NL; o++) m_head[o] = NIL_I;
    // only the largest order that fits gets seeded
    for (int o = TOP_ORD; o >= 0; o--) begin
      sz = 1 << o;
      a = (r + sz - 1) & ~(sz - 1);
      if (a + sz <= t) begin
        while (a + sz <= t) begin
          list_push(o, a);
          tag_block(a, o);
          a += sz;
        end
        break;
      end
    end
  endfunction

  function automatic alloc_rsp_t model_alloc(int cnt);
    alloc_rsp_t r;
    int o;
    int addr;
    int bud;
    r = '{ST_INVAL, 0, 0};
    if (cnt == 0) return r;
    o = 0;
    while ((1 << o) < cnt && o < TOP_ORD) o++;
    if (o >= TOP_ORD) return r;
    for (int cur = o; cur <= TOP_ORD; cur++) begin
      if (m_head[cur] < NPAGES) begin
        addr = list_pop(cur);
        // split down, pushing each upper half
        while (cur > o) begin
          cur--;
          bud = addr + (1 << cur);
          tag_block(bud, cur);
          list_push(cur, bud);
          mark_block(bud, cur, 1'b0);
        end
        tag_block(addr, o);
        mark_block(addr, o, 1'b1);
        return '{ST_DONE, addr, o};
      end
    end
    return '{ST_NOBLK, 0, 0};
  endfunction

  function automatic alloc_rsp_t model_free(int cnt, int idx);
    alloc_rsp_t r;
    int s;
    int o;
    int bud;
    r = '{ST_INVAL, 0, 0};
    if (cnt == 0 || idx >= m_region) return r;
    s = m_start[idx];
    o = m_order[idx];
    if (s >= m_region || o < 0 || o > TOP_ORD) return r;
    if ((1 << o) < cnt || (s & ((1 << o) - 1)) != 0) return r;
    if (block_is_free(s, o)) return '{ST_DUP, s, o};
    mark_block(s, o, 1'b0);
    // merge upwards while the buddy is a free block of the same order
    while (o < TOP_ORD) begin
      bud = s ^ (1 << o);
      if (bud >= m_region) break;
      if (m_start[bud] != bud || m_order[bud] != o || m_used[bud]) break;
      list_unlink(o, bud);
      if (bud < s) s = bud;
      o++;
      tag_block(s, o);
    end
    tag_block(s, o);
    list_push(o, s);
    return '{ST_DONE, s, o};
  endfunction

  function automatic alloc_rsp_t model_request(logic [1:0] k, int cnt, int idx);
    case (k)
      K_ALLOC: return model_alloc(cnt);
      K_FREE:  return model_free(cnt, idx);
      K_INIT: begin
        seed_lists();
        return '{ST_DONE, 0, 0};
      end
      default: return '{ST_INVAL, 0, 0};
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  task automatic send_req(logic [1:0] k, int cnt, int idx);
    int gap;
    alloc_rsp_t r;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= k;
    in_pg_cnt     <= 11'(cnt);
    in_page_index <= 10'(idx);
    do @(posedge clk); while (in_stall);
    r = model_request(k, cnt, idx);
    rsp_pending.push_back(r);
    if (k == K_INIT) begin
      live_page.delete();
      live_order.delete();
    end
    if (k == K_ALLOC && r.status == ST_DONE) begin
      live_page.push_back(r.page);
      live_order.push_back(r.order);
    end
  endtask

  // drop valid at the acceptance step, then let everything drain
  task automatic drain();
    in_valid <= 1'b0;
    wait (rsp_pending.size() == 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CW'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TOTAL) m_total = val;
    else m_rsv = val;
  endtask

  task automatic set_region(int total, int rsv);
    write_reg(CFG_TOTAL, total);
    write_reg(CFG_RSV, rsv);
  endtask

  task automatic free_live(int k, bit whole);
    int p;
    int o;
    p = live_page[k];
    o = live_order[k];
    live_page.delete(k);
    live_order.delete(k);
    if (whole) send_req(K_FREE, 1 << o, p);
    else send_req(K_FREE, $urandom_range(1, 1 << o), p + $urandom_range(0, (1 << o) - 1));
  endtask

  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 8);
    if (r < 85) return $urandom_range(1, 64);
    if (r < 95) return $urandom_range(65, 512);
    if (r < 98) return $urandom_range(513, 1024);
    return 0;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_before_init();
    // no lists and no region yet
    send_req(K_ALLOC, 1, 0);
    send_req(K_FREE, 1, 0);
    send_req(3, 5, 1023);
  endtask

  task automatic test_directed();
    set_region(1024, 0);
    send_req(K_INIT, 0, 0);
    send_req(K_ALLOC, 0, 0);
    send_req(K_ALLOC, 513, 0);
    send_req(K_ALLOC, 1024, 0);
    send_req(K_ALLOC, 512, 0);
    send_req(K_ALLOC, 1, 0);
    send_req(K_ALLOC, 3, 0);
    send_req(K_FREE, 2, 512);
    send_req(K_FREE, 1, 512);
    send_req(K_FREE, 1, 512);
    send_req(K_FREE, 0, 0);
    send_req(K_FREE, 1, 1023);
    send_req(3, 2047, 1023);
    // all pages reserved, clipped to the region
    set_region(2047, 2047);
    send_req(K_INIT, 0, 0);
    send_req(K_ALLOC, 1, 0);
    send_req(K_FREE, 1, 5);
    set_region(0, 0);
    send_req(K_INIT, 0, 0);
    send_req(K_ALLOC, 1, 0);
    send_req(K_FREE, 1, 0);
    set_region(100, 7);
    send_req(K_INIT, 0, 0);
    send_req(K_FREE, 1, 3);
    send_req(K_ALLOC, 32, 0);
    send_req(K_ALLOC, 32, 0);
    send_req(K_FREE, 1, 99);
  endtask

  task automatic test_pressure();
    set_region(1024, 1);
    send_req(K_INIT, 0, 0);
    hold_off_req = 1'b1;
    no_idle = 1'b1;
    repeat (12) send_req(K_ALLOC, $urandom_range(1, 4), 0);
    no_idle = 1'b0;
  endtask

  task automatic test_random(int n, int total, int rsv);
    int r;
    set_region(total, rsv);
    send_req(K_INIT, 0, 0);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 20) no_idle = ~no_idle;
      r = $urandom_range(0, 99);
      if (r < 45) send_req(K_ALLOC, pick_count(), 0);
      else if (r < 85 && live_page.size() > 0)
        free_live($urandom_range(0, live_page.size() - 1), r < 70);
      else if (r < 97) send_req(K_FREE, $urandom_range(0, 1024), $urandom_range(0, 1023));
      else if (r < 98) send_req(K_INIT, 0, 0);
      else send_req(3, $urandom_range(0, 2047), $urandom_range(0, 1023));
    end
    no_idle = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_before_init();
    test_directed();
    test_pressure();
    test_random(90, 1024, 0);
    test_random(90, 64, 0);
    test_random(90, 777, 300);
    test_random(90, 1024, 1023);
    test_random(90, 513, 33);
    test_random(90, 2047, 17);
    drain();
    repeat (50) @(posedge clk);
    if (mismatches == 0) $display("buddy_page_allocator_top test passed");
    else $display("buddy_page_allocator_top test failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        n = 300;
      end else begin
        n = no_idle ? 0 : $urandom_range(0, 8);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    alloc_rsp_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (rsp_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result status=%0d page=%0d order=%0d",
                                       out_status, out_block_page, out_block_order);
      end else begin
        e = rsp_pending.pop_front();
        if (out_status !== e.status || out_block_page !== page_t'(e.page) ||
            out_block_order !== ord_t'(e.order)) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                     e.status, e.page, e.order,
                     out_status, out_block_page, out_block_order);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: cycles with no item moving on any channel
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("buddy_page_allocator_top test failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NPAGES; i++) begin
      m_used[i] = 1'b0;
      m_start[i] = 0;
      m_order[i] = 0;
      m_next[i] = NIL_I;
      m_prev[i] = NIL_I;
    end
    for (int o = 0; o < NL; o++) m_head[o] = NIL_I;
  end

endmodule
